// ===== rtl/fpt_pkg.sv =====
// Shared constants, status codes and controller/datapath interface types.
package fpt_pkg;

	// Default geometry of the partition table
	localparam int SLOT_COUNT_DEF     = 64;
	localparam int PARTITION_SIZE_DEF = 512;

	// Field widths of the request and answer
	localparam int PID_W    = 16;
	localparam int PSIZE_W  = 9;
	localparam int SLOTF_W  = 6;
	localparam int BASE_W   = 15;
	localparam int HEAP_W   = 16;
	localparam int STATUS_W = 3;

	// Request operations
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Answer status codes
	localparam logic [STATUS_W-1:0] ST_NEW       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FREED     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic start;   // capture request, reset scan state
		logic scan;    // walk the table
		logic finish;  // resolve, update table, load answer register
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic scan_end; // match found or last slot compared
		logic out_free; // answer register can take a new answer
	} dp_sts_t;

endpackage

// ===== rtl/fpt_ctrl.sv =====
// Sequencer for one request: capture, table scan, resolve.
module fpt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  fpt_pkg::dp_sts_t sts,
	output fpt_pkg::dp_cmd_t cmd
);
	import fpt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t state_q;

	// Commands decode from the current state
	always_comb begin
		in_ready   = (state_q == S_IDLE);
		cmd.start  = (state_q == S_IDLE) && in_valid;
		cmd.scan   = (state_q == S_SCAN);
		cmd.finish = (state_q == S_FINISH) && sts.out_free;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sts.scan_end) state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/fpt_datapath.sv =====
// Partition table storage, scan pipeline, answer computation and answer register.
module fpt_datapath #(
	parameter int SLOT_COUNT     = fpt_pkg::SLOT_COUNT_DEF,
	parameter int PARTITION_SIZE = fpt_pkg::PARTITION_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fpt_pkg::dp_cmd_t               cmd,
	output fpt_pkg::dp_sts_t               sts,
	input  logic                           operation,
	input  logic [fpt_pkg::PID_W-1:0]      pid,
	input  logic [fpt_pkg::PSIZE_W-1:0]    program_size,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [fpt_pkg::SLOTF_W-1:0]    slot,
	output logic [fpt_pkg::BASE_W-1:0]     base_address,
	output logic [fpt_pkg::HEAP_W-1:0]     heap_address,
	output logic [fpt_pkg::STATUS_W-1:0]   status
);
	import fpt_pkg::*;

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int PS_W   = $clog2(PARTITION_SIZE + 1);
	localparam int PROD_W = SLOT_W + PS_W;
	localparam int WIDE_W = PROD_W + 16;
	localparam int SXT_W  = SLOT_W + SLOTF_W;
	localparam int ENT_W  = PSIZE_W + PID_W;
	localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOT_COUNT - 1);

	// Table storage: {code size, owner} per slot, plus in-use flags
	logic [ENT_W-1:0]      mem_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] in_use_q;

	// Captured request
	logic               op_q;
	logic [PID_W-1:0]   pid_q;
	logic [PSIZE_W-1:0] psize_q;

	// Scan control
	logic [SLOT_W-1:0] cnt_q;
	logic              issued_all_q;
	logic              cmp_valid_s1;
	logic              scan_end_q;
	logic              match_q;
	logic              have_free_q;

	// Scan read stage
	logic [ENT_W-1:0]   rd_s1;
	logic               used_s1;
	logic [SLOT_W-1:0]  idx_s1;

	// Scan results
	logic [SLOT_W-1:0]  match_idx_q;
	logic [PSIZE_W-1:0] match_size_q;
	logic [SLOT_W-1:0]  free_idx_q;

	// Answer register
	logic                out_valid_q;
	logic [SLOTF_W-1:0]  slot_q;
	logic [BASE_W-1:0]   base_q;
	logic [HEAP_W-1:0]   heap_q;
	logic [STATUS_W-1:0] status_q;

	logic issue, cmp_live, hit, take_free, last_cmp;
	logic [PID_W-1:0]   owner_s1;
	logic [PSIZE_W-1:0] size_s1;

	// Compare stage of the scan
	always_comb begin
		owner_s1  = rd_s1[PID_W-1:0];
		size_s1   = rd_s1[ENT_W-1:PID_W];
		issue     = cmd.scan && !issued_all_q;
		cmp_live  = cmd.scan && cmp_valid_s1 && !scan_end_q;
		hit       = cmp_live && used_s1 && (owner_s1 == pid_q);
		take_free = cmp_live && !used_s1 && !have_free_q;
		last_cmp  = cmp_live && (idx_s1 == LAST);
	end

	logic                res_valid;
	logic [STATUS_W-1:0] res_status;
	logic [SLOT_W-1:0]   res_idx;
	logic [PSIZE_W-1:0]  res_size;
	logic                do_alloc, do_free;
	logic [PROD_W-1:0]   base_full;
	logic [WIDE_W-1:0]   base_wide, heap_wide;
	logic [SXT_W-1:0]    slot_wide;

	// Resolve the scan into an answer and a table update
	always_comb begin
		res_valid  = 1'b0;
		res_status = ST_NOT_FOUND;
		res_idx    = match_idx_q;
		res_size   = match_size_q;
		do_alloc   = 1'b0;
		do_free    = 1'b0;
		if (match_q) begin
			res_valid = 1'b1;
			if (op_q == OP_ALLOC) begin
				res_status = ST_PRESENT;
			end else begin
				res_status = ST_FREED;
				do_free    = 1'b1;
			end
		end else if (op_q == OP_FREE) begin
			res_status = ST_NOT_FOUND;
		end else if (!have_free_q) begin
			res_status = ST_FULL;
		end else begin
			res_valid  = 1'b1;
			res_status = ST_NEW;
			res_idx    = free_idx_q;
			res_size   = psize_q;
			do_alloc   = 1'b1;
		end
		base_full = {{PS_W{1'b0}}, res_idx} * PROD_W'(PARTITION_SIZE);
		base_wide = WIDE_W'(base_full);
		heap_wide = base_wide + WIDE_W'(res_size) + WIDE_W'(1);
		slot_wide = SXT_W'(res_idx);
		if (!res_valid) begin
			base_wide = '0;
			heap_wide = '0;
			slot_wide = '0;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			issued_all_q <= 1'b0;
			cmp_valid_s1 <= 1'b0;
			scan_end_q   <= 1'b0;
			match_q      <= 1'b0;
			have_free_q  <= 1'b0;
			in_use_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.start) begin
				cnt_q        <= '0;
				issued_all_q <= 1'b0;
				cmp_valid_s1 <= 1'b0;
				scan_end_q   <= 1'b0;
				match_q      <= 1'b0;
				have_free_q  <= 1'b0;
			end else if (cmd.scan) begin
				if (issue) begin
					cnt_q <= cnt_q + SLOT_W'(1);
					if (cnt_q == LAST) issued_all_q <= 1'b1;
				end
				cmp_valid_s1 <= issue;
				if (hit) match_q <= 1'b1;
				if (take_free) have_free_q <= 1'b1;
				if (hit || last_cmp) scan_end_q <= 1'b1;
			end
			if (cmd.finish) begin
				if (do_alloc) in_use_q[free_idx_q] <= 1'b1;
				if (do_free) in_use_q[match_idx_q] <= 1'b0;
			end
			// answer register handshake
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers and table read port
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q    <= operation;
			pid_q   <= pid;
			psize_q <= program_size;
		end
		if (issue) begin
			rd_s1   <= mem_q[cnt_q];
			used_s1 <= in_use_q[cnt_q];
			idx_s1  <= cnt_q;
		end
		if (hit) begin
			match_idx_q  <= idx_s1;
			match_size_q <= size_s1;
		end
		if (take_free) free_idx_q <= idx_s1;
		if (cmd.finish) begin
			slot_q   <= slot_wide[SLOTF_W-1:0];
			base_q   <= base_wide[BASE_W-1:0];
			heap_q   <= heap_wide[HEAP_W-1:0];
			status_q <= res_status;
		end
	end

	// Table write port: a new owner takes the claimed slot
	always_ff @(posedge clk) begin
		if (cmd.finish && do_alloc) begin
			mem_q[free_idx_q] <= {psize_q, pid_q};
		end
	end

	always_comb begin
		sts.scan_end = scan_end_q;
		sts.out_free = !out_valid_q || out_ready;
		out_valid    = out_valid_q;
		slot         = slot_q;
		base_address = base_q;
		heap_address = heap_q;
		status       = status_q;
	end

endmodule

// ===== rtl/fixed_partition_process_table_top.sv =====
// Top level of the fixed-partition process table.
//
// Requests arrive on the in channel (in_valid/in_ready) with operation, pid
// and program_size; answers leave on the out channel (out_valid/out_ready)
// with slot, base_address, heap_address and status.
// One request is handled at a time. After a transfer the table is scanned one
// slot per cycle through the registered read port of the owner memory; the
// scan ends early when the pid matches a slot before the last. A new request
// is taken only after the previous one has resolved, so the scan over the
// single table read port sets the rate of input transfers.
// The answer sits in an output register; the next request may be taken and
// scanned while the receiver stalls, and it waits to resolve until that
// answer has been transferred.
// Reset frees every slot at once through per-slot in-use flags; owner and
// code size entries need no clearing and are used only for slots in use.
module fixed_partition_process_table_top #(
	parameter int SLOT_COUNT     = fpt_pkg::SLOT_COUNT_DEF,
	parameter int PARTITION_SIZE = fpt_pkg::PARTITION_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           operation,
	input  logic [fpt_pkg::PID_W-1:0]      pid,
	input  logic [fpt_pkg::PSIZE_W-1:0]    program_size,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [fpt_pkg::SLOTF_W-1:0]    slot,
	output logic [fpt_pkg::BASE_W-1:0]     base_address,
	output logic [fpt_pkg::HEAP_W-1:0]     heap_address,
	output logic [fpt_pkg::STATUS_W-1:0]   status
);
	import fpt_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	fpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fpt_datapath #(
		.SLOT_COUNT     (SLOT_COUNT),
		.PARTITION_SIZE (PARTITION_SIZE)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (operation),
		.pid          (pid),
		.program_size (program_size),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.slot         (slot),
		.base_address (base_address),
		.heap_address (heap_address),
		.status       (status)
	);

endmodule

// ===== tb/sv/partition_table_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the partition table: predicts every answer and checks the out channel.
module partition_table_checker #(
	parameter int SLOT_COUNT     = fpt_pkg::SLOT_COUNT_DEF,
	parameter int PARTITION_SIZE = fpt_pkg::PARTITION_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           operation,
	input  logic [fpt_pkg::PID_W-1:0]      pid,
	input  logic [fpt_pkg::PSIZE_W-1:0]    program_size,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [fpt_pkg::SLOTF_W-1:0]    slot,
	input  logic [fpt_pkg::BASE_W-1:0]     base_address,
	input  logic [fpt_pkg::HEAP_W-1:0]     heap_address,
	input  logic [fpt_pkg::STATUS_W-1:0]   status,
	output int                             error_count,
	output int                             pending
);
	import fpt_pkg::*;

	typedef struct packed {
		logic [SLOTF_W-1:0]  slot;
		logic [BASE_W-1:0]   base;
		logic [HEAP_W-1:0]   heap;
		logic [STATUS_W-1:0] status;
	} answer_t;

	// Shadow copy of the partition table
	bit                 busy       [SLOT_COUNT];
	logic [PID_W-1:0]   owner_pid  [SLOT_COUNT];
	logic [PSIZE_W-1:0] code_words [SLOT_COUNT];

	answer_t answers_due [$];
	int      errs = 0;

	// Look up the pid, claim or release a slot, and build the answer
	function automatic answer_t predict_answer(input logic op, input logic [PID_W-1:0] p,
			input logic [PSIZE_W-1:0] sz);
		answer_t     ans;
		bit          hit;
		bit          have_free;
		int          hit_slot;
		int          free_slot;
		int          idx;
		int unsigned base;
		int unsigned heap;
		ans       = '0;
		hit       = 1'b0;
		have_free = 1'b0;
		hit_slot  = 0;
		free_slot = 0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (!hit && busy[i] && owner_pid[i] == p) begin
				hit      = 1'b1;
				hit_slot = i;
			end
			if (!hit && !busy[i] && !have_free) begin
				have_free = 1'b1;
				free_slot = i;
			end
		end
		if (hit || (op == OP_ALLOC && have_free)) begin
			idx = hit ? hit_slot : free_slot;
			if (!hit) begin
				busy[idx]       = 1'b1;
				owner_pid[idx]  = p;
				code_words[idx] = sz;
				ans.status      = ST_NEW;
			end else if (op == OP_FREE) begin
				// released slot still reports its stored code size
				busy[idx]  = 1'b0;
				ans.status = ST_FREED;
			end else begin
				// existing owner keeps its original code size
				ans.status = ST_PRESENT;
			end
			base     = idx * PARTITION_SIZE;
			heap     = base + 32'(code_words[idx]) + 1;
			ans.slot = idx[SLOTF_W-1:0];
			ans.base = base[BASE_W-1:0];
			ans.heap = heap[HEAP_W-1:0];
		end else begin
			ans.status = (op == OP_FREE) ? ST_NOT_FOUND : ST_FULL;
		end
		return ans;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errs++;
		end
	endtask

	// Answers are checked before the same-edge request is predicted
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			foreach (busy[i]) busy[i] = 1'b0;
			answers_due.delete();
			error_count <= 0;
			pending     <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected answer, expected none, actual slot %0d status %0d",
						$time, slot, status);
					errs++;
				end else begin
					want = answers_due.pop_front();
					check_field("slot", 32'(want.slot), 32'(slot));
					check_field("base_address", 32'(want.base), 32'(base_address));
					check_field("heap_address", 32'(want.heap), 32'(heap_address));
					check_field("status", 32'(want.status), 32'(status));
				end
			end
			if (in_valid && in_ready)
				answers_due.push_back(predict_answer(operation, pid, program_size));
			error_count <= errs;
			pending     <= answers_due.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the partition table testbench: clock, reset, request stimulus and verdict.
module testbench;
	import fpt_pkg::*;

	localparam int RANDOM_ITEMS  = 1030;
	localparam int IDLE_LIMIT    = 5000;
	localparam int SETTLE_CYCLES = 120;

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic                 operation    = OP_ALLOC;
	logic [PID_W-1:0]     pid          = '0;
	logic [PSIZE_W-1:0]   program_size = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [SLOTF_W-1:0]   slot;
	logic [BASE_W-1:0]    base_address;
	logic [HEAP_W-1:0]    heap_address;
	logic [STATUS_W-1:0]  status;
	int                   error_count;
	int                   pending;

	// Pids the stimulus believes hold a slot, used to aim lookups and frees
	logic [PID_W-1:0] live_pids [$];
	int               items_sent = 0;
	bit               tx_steady  = 1'b0;
	bit               rx_steady  = 1'b0;
	int               rx_hold    = 0;
	int               idle_cycles = 0;

	fixed_partition_process_table_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.pid          (pid),
		.program_size (program_size),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.slot         (slot),
		.base_address (base_address),
		.heap_address (heap_address),
		.status       (status)
	);

	partition_table_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.pid          (pid),
		.program_size (program_size),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.slot         (slot),
		.base_address (base_address),
		.heap_address (heap_address),
		.status       (status),
		.error_count  (error_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long
	function automatic int pick_idle(input bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	function automatic logic [PSIZE_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return '0;
		if (r < 4)
			return '1;
		return PSIZE_W'($urandom_range(0, 511));
	endfunction

	function automatic int live_index(input logic [PID_W-1:0] p);
		foreach (live_pids[i])
			if (live_pids[i] == p)
				return i;
		return -1;
	endfunction

	// Receiver side: random stalls, some of them long
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold   <= rx_hold - 1;
		end else if (rx_steady || $urandom_range(0, 99) < 65) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b0;
			rx_hold   <= pick_idle(1'b0);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// One request transfer; called and returns at a rising edge
	task automatic issue(input logic op, input logic [PID_W-1:0] p,
			input logic [PSIZE_W-1:0] sz);
		int gap;
		int idx;
		gap = pick_idle(tx_steady);
		idx = live_index(p);
		if (op == OP_ALLOC && idx < 0 && live_pids.size() < SLOT_COUNT_DEF)
			live_pids.push_back(p);
		else if (op == OP_FREE && idx >= 0)
			live_pids.delete(idx);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		pid          <= p;
		program_size <= sz;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		items_sent++;
	endtask

	// Hold off new requests until every answer is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic fill_burst(input int n);
		repeat (n) issue(OP_ALLOC, PID_W'($urandom_range(0, 65535)), pick_size());
	endtask

	task automatic drain_burst(input int n);
		repeat (n) begin
			if (live_pids.size() > 0 && $urandom_range(0, 99) < 85)
				issue(OP_FREE, live_pids[$urandom_range(0, live_pids.size() - 1)],
					PSIZE_W'($urandom_range(0, 511)));
			else
				issue(OP_FREE, PID_W'($urandom_range(0, 65535)),
					PSIZE_W'($urandom_range(0, 511)));
		end
	endtask

	// Lookups, frees and fresh claims mixed over the live pids
	task automatic mixed_burst(input int n);
		int               r;
		logic [PID_W-1:0] p;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (live_pids.size() > 0 && r < 65)
				p = live_pids[$urandom_range(0, live_pids.size() - 1)];
			else
				p = PID_W'($urandom_range(0, 65535));
			issue((r < 40 || (r >= 65 && r < 85)) ? OP_ALLOC : OP_FREE, p, pick_size());
		end
	endtask

	initial begin
		int kind;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, reuse of the lowest free slot, errors on free
		issue(OP_ALLOC, 16'h0000, 9'd0);
		issue(OP_ALLOC, 16'h0000, 9'd511);   // existing owner, size ignored
		issue(OP_ALLOC, 16'hFFFF, 9'd511);
		issue(OP_FREE,  16'h0000, 9'd0);
		issue(OP_FREE,  16'h0000, 9'd0);     // former owner no longer matches
		issue(OP_ALLOC, 16'h5555, 9'h155);   // lowest free slot reused
		issue(OP_ALLOC, 16'hAAAA, 9'h0AA);
		issue(OP_ALLOC, 16'hFFFF, 9'd0);
		issue(OP_FREE,  16'h1234, 9'd511);   // unknown pid
		issue(OP_FREE,  16'hFFFF, 9'd0);
		issue(OP_ALLOC, 16'hFFFF, 9'd1);
		issue(OP_FREE,  16'h5555, 9'd0);
		issue(OP_FREE,  16'hAAAA, 9'd0);
		issue(OP_FREE,  16'hFFFF, 9'd0);
		issue(OP_FREE,  16'h0000, 9'd0);     // free on an empty table
		wait_drained();

		// Random: first fill runs past a full table, then mixed bursts
		fill_burst(70);
		while (items_sent < RANDOM_ITEMS) begin
			kind      = $urandom_range(0, 2);
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 5) == 0)
				wait_drained();
			case (kind)
				0: begin
					fill_burst($urandom_range(20, 75));
				end
				1: begin
					drain_burst($urandom_range(10, live_pids.size() + 10));
				end
				default: begin
					mixed_burst($urandom_range(15, 40));
				end
			endcase
		end
		in_valid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
